// File: sv/tffm_pkg.sv
// Shared constants and types for the text frame field matcher.
// No dependencies; every other file of the block refers to it by scoped names.
package tffm_pkg;

    // Longest field in characters (1..8); further characters raise overflow
    localparam int FIELD_CHARS = 8;

    localparam int ByteW   = 8;
    localparam int NameW   = 64;
    localparam int NameB   = NameW / ByteW;
    localparam int LenW    = 4;
    localparam int CfgIdxW = 2;

    // Frame delimiters
    localparam logic [ByteW-1:0] CH_AT     = 8'h40;   // '@'
    localparam logic [ByteW-1:0] CH_HASH   = 8'h23;   // '#'
    localparam logic [ByteW-1:0] CH_DOLLAR = 8'h24;   // '$'
    localparam logic [ByteW-1:0] CH_PCT    = 8'h25;   // '%'
    localparam logic [ByteW-1:0] CH_BANG   = 8'h21;   // '!'
    localparam logic [ByteW-1:0] CH_NONE   = 8'h00;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_MASTER   = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_SLAVE    = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_VARIABLE = 2'd2;

    typedef logic [LenW-1:0] t_index;

    typedef struct packed {
        logic [NameW-1:0] master;
        logic [NameW-1:0] slave;
        logic [NameW-1:0] variable;
    } t_names;

    typedef struct packed {
        logic             frame_match;
        logic [NameW-1:0] value_bytes;
        logic [LenW-1:0]  value_length;
        logic             field_overflow;
    } t_result;

endpackage

// File: sv/tffm_ifs.sv
// Handshake channels of the text frame field matcher: bytes in, results out, config writes.
// Depends on tffm_pkg for field widths.
interface tffm_byte_if;
    logic                     valid;
    logic                     ready;
    logic [tffm_pkg::ByteW-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tffm_res_if;
    logic                       valid;
    logic                       ready;
    logic                       frame_match;
    logic [tffm_pkg::NameW-1:0] value_bytes;
    logic [tffm_pkg::LenW-1:0]  value_length;
    logic                       field_overflow;

    modport source (output valid, output frame_match, output value_bytes,
                    output value_length, output field_overflow, input ready);
    modport sink   (input valid, input frame_match, input value_bytes,
                    input value_length, input field_overflow, output ready);
endinterface

interface tffm_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [tffm_pkg::CfgIdxW-1:0] index;
    logic [tffm_pkg::NameW-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/tffm_cfg_regs.sv
// Configuration registers holding the three expected names.
// Depends on tffm_pkg and tffm_cfg_if.
module tffm_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tffm_cfg_if.sink          i_cfg,
    output tffm_pkg::t_names  o_names
);

    tffm_pkg::t_names r_names;

    // Always able to take a write
    assign i_cfg.ready = 1'b1;
    assign o_names     = r_names;

    // Decode the index and store the word; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_names <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                tffm_pkg::REG_MASTER:   r_names.master   <= i_cfg.data;
                tffm_pkg::REG_SLAVE:    r_names.slave    <= i_cfg.data;
                tffm_pkg::REG_VARIABLE: r_names.variable <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

// File: sv/tffm_in_reg.sv
// Input register: captures one received byte and holds it until the parser takes it.
// Depends on tffm_pkg and tffm_byte_if.
module tffm_in_reg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    tffm_byte_if.sink                 i_rx,
    input  logic                      i_take,
    output logic                      o_valid,
    output logic [tffm_pkg::ByteW-1:0] o_byte
);

    logic                       r_valid;
    logic [tffm_pkg::ByteW-1:0] r_byte;

    // Accept when empty or when the held byte leaves this cycle
    assign i_rx.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_byte     = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

endmodule

// File: sv/tffm_parser.sv
// Frame parser: phase, character index, running name match flags and value store.
// One byte per cycle while the output queue has room; depends on tffm_pkg.
module tffm_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [tffm_pkg::ByteW-1:0] i_byte,
    input  tffm_pkg::t_names           i_names,
    input  logic                       i_q_full,
    output logic                       o_take,
    output logic                       o_push,
    output tffm_pkg::t_result          o_result
);

    typedef enum logic [2:0] {
        PH_WAIT   = 3'd0,
        PH_MASTER = 3'd1,
        PH_SLAVE  = 3'd2,
        PH_VAR    = 3'd3,
        PH_VALUE  = 3'd4
    } t_phase;

    t_phase                     r_phase, n_phase, adv_phase;
    tffm_pkg::t_index           r_idx, n_idx;
    logic [2:0]                 r_flags, n_flags;
    logic [tffm_pkg::NameW-1:0] r_value, n_value;
    logic                       r_ovf, n_ovf;

    logic [tffm_pkg::NameW-1:0] cur_name;
    logic [2:0]                 cur_bit;
    logic [tffm_pkg::ByteW-1:0] exp_delim;
    logic [tffm_pkg::ByteW-1:0] want;
    logic                       tail_zero;
    logic                       is_delim;
    logic                       at_limit;
    logic                       emit;

    // Name register, flag bit, expected delimiter and next phase per phase
    always_comb begin
        case (r_phase)
            PH_MASTER: begin
                cur_name  = i_names.master;
                cur_bit   = 3'b001;
                exp_delim = tffm_pkg::CH_HASH;
                adv_phase = PH_SLAVE;
            end
            PH_SLAVE: begin
                cur_name  = i_names.slave;
                cur_bit   = 3'b010;
                exp_delim = tffm_pkg::CH_DOLLAR;
                adv_phase = PH_VAR;
            end
            PH_VAR: begin
                cur_name  = i_names.variable;
                cur_bit   = 3'b100;
                exp_delim = tffm_pkg::CH_PCT;
                adv_phase = PH_VALUE;
            end
            PH_VALUE: begin
                cur_name  = i_names.variable;
                cur_bit   = 3'b000;
                exp_delim = tffm_pkg::CH_BANG;
                adv_phase = PH_WAIT;
            end
            default: begin
                cur_name  = i_names.variable;
                cur_bit   = 3'b000;
                exp_delim = tffm_pkg::CH_NONE;
                adv_phase = PH_WAIT;
            end
        endcase
    end

    // Byte of the expected name at the current position
    assign want = cur_name[{r_idx[2:0], 3'b000} +: tffm_pkg::ByteW];

    // Register bytes past the received length must all be zero
    always_comb begin
        tail_zero = 1'b1;
        for (int b = 0; b < tffm_pkg::NameB; b++) begin
            if ((tffm_pkg::t_index'(b) >= r_idx)
                && (cur_name[b*tffm_pkg::ByteW +: tffm_pkg::ByteW] != '0)) begin
                tail_zero = 1'b0;
            end
        end
    end

    assign is_delim = (i_byte == tffm_pkg::CH_HASH) || (i_byte == tffm_pkg::CH_DOLLAR)
                   || (i_byte == tffm_pkg::CH_PCT)  || (i_byte == tffm_pkg::CH_BANG);
    assign at_limit = (r_idx >= tffm_pkg::t_index'(tffm_pkg::FIELD_CHARS));

    assign o_take = i_valid && !i_q_full;

    // Next state for the byte in the input register
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_flags = r_flags;
        n_value = r_value;
        n_ovf   = r_ovf;
        emit    = 1'b0;
        if (o_take) begin
            if (i_byte == tffm_pkg::CH_AT) begin
                // Restart the frame
                n_phase = PH_MASTER;
                n_idx   = '0;
                n_flags = 3'b001;
                n_value = '0;
                n_ovf   = 1'b0;
            end else if (r_phase == PH_WAIT) begin
                n_phase = PH_WAIT;
            end else if (is_delim) begin
                if (i_byte != exp_delim) begin
                    // Out-of-order delimiter: drop the frame
                    n_phase = PH_WAIT;
                end else if (r_phase == PH_VALUE) begin
                    emit    = 1'b1;
                    n_phase = PH_WAIT;
                end else begin
                    // Close the name field and open the next one
                    n_phase = adv_phase;
                    n_idx   = '0;
                    if (adv_phase == PH_VALUE) begin
                        n_flags = tail_zero ? r_flags : (r_flags & ~cur_bit);
                        n_value = '0;
                    end else begin
                        n_flags = (tail_zero ? r_flags : (r_flags & ~cur_bit))
                                | (cur_bit << 1);
                    end
                end
            end else if (at_limit) begin
                n_ovf   = 1'b1;
                n_flags = r_flags & ~cur_bit;
            end else begin
                if (r_phase == PH_VALUE) begin
                    n_value[{r_idx[2:0], 3'b000} +: tffm_pkg::ByteW] = i_byte;
                end else if (want != i_byte) begin
                    n_flags = r_flags & ~cur_bit;
                end
                n_idx = r_idx + 1'b1;
            end
        end
    end

    // Result of the closing byte, taken by the output queue
    assign o_push                  = emit;
    assign o_result.frame_match    = (r_flags == 3'b111) && !r_ovf;
    assign o_result.value_bytes    = r_value;
    assign o_result.value_length   = r_idx;
    assign o_result.field_overflow = r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_idx   <= '0;
            r_flags <= '0;
            r_value <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_flags <= n_flags;
            r_value <= n_value;
            r_ovf   <= n_ovf;
        end
    end

    // A closed frame always leaves the parser waiting for the next '@'
    a_emit_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_phase == PH_WAIT))
        else $error("parser not waiting after frame end");

    // Character index never passes the field limit
    a_idx_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= tffm_pkg::t_index'(tffm_pkg::FIELD_CHARS))
        else $error("character index beyond field limit");

    // Only a byte actually taken can close a frame
    a_push_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_take && (r_phase == PH_VALUE)))
        else $error("result without a taken closing byte");

endmodule

// File: sv/tffm_out_queue.sv
// Two-word result queue that parts the parser from the result consumer.
// Depends on tffm_pkg and tffm_res_if.
module tffm_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tffm_pkg::t_result i_result,
    output logic              o_full,
    tffm_res_if.source        o_res
);

    tffm_pkg::t_result r_data [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_cnt;
    logic              pop;

    assign o_full    = (r_cnt == 2'd2);
    assign pop       = o_res.valid && o_res.ready;
    assign o_res.valid = (r_cnt != 2'd0);

    // Drive the head word
    assign o_res.frame_match    = r_data[r_rd_ptr].frame_match;
    assign o_res.value_bytes    = r_data[r_rd_ptr].value_bytes;
    assign o_res.value_length   = r_data[r_rd_ptr].value_length;
    assign o_res.field_overflow = r_data[r_rd_ptr].field_overflow;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)    r_rd_ptr <= ~r_rd_ptr;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
    end

    // Store words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_result;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("queue count out of range");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("queue count lost a push");

endmodule

// File: sv/text_frame_field_matcher_unit.sv
// Top level of the text frame field matcher.
// Depends on tffm_pkg, tffm_ifs, tffm_cfg_regs, tffm_in_reg, tffm_parser, tffm_out_queue.
//
//  channel | dir | payload                                           | word moves when
//  i_rx    | in  | rx_byte[7:0]                                      | valid & ready
//  o_res   | out | frame_match, value_bytes[63:0], value_length[3:0], | valid & ready
//          |     | field_overflow                                    |
//  i_cfg   | in  | index[1:0], data[63:0]                            | valid & ready
//
// One received byte per cycle while the result queue has room; a byte is parsed while it
// sits in the input register, and the result word of a closing '!' is registered in the
// output queue, from which it is valid on o_res.
// Reset (i_rst_n low at a clock edge) clears the parser, the queue and the names.
// A stalled o_res fills the two-word queue; i_rx.ready then drops as soon as a byte
// waits in the input register.
// The config port takes a write every cycle.
module text_frame_field_matcher_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tffm_byte_if.sink  i_rx,
    tffm_res_if.source o_res,
    tffm_cfg_if.sink   i_cfg
);

    tffm_pkg::t_names           names;
    tffm_pkg::t_result          result;
    logic                       in_valid;
    logic [tffm_pkg::ByteW-1:0] in_byte;
    logic                       take;
    logic                       push;
    logic                       q_full;

    tffm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_names (names)
    );

    tffm_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (take),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    tffm_parser u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_valid),
        .i_byte   (in_byte),
        .i_names  (names),
        .i_q_full (q_full),
        .o_take   (take),
        .o_push   (push),
        .o_result (result)
    );

    tffm_out_queue u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (result),
        .o_full   (q_full),
        .o_res    (o_res)
    );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for text_frame_field_matcher_unit: frames of received bytes,
// name register settings and backpressure on the result channel, checked word by word.
// Depends on tffm_pkg, the channel interfaces in tffm_ifs and the RTL of the block.
module testbench;

    localparam int HOLD_CYCLES    = 90;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TOTAL_BYTES    = 600;
    localparam int MAX_REPORTS    = 40;

    typedef enum logic [2:0] {
        WAIT_START, IN_MASTER, IN_SLAVE, IN_VARIABLE, IN_VALUE
    } t_phase;

    typedef enum int {
        NAME_EMPTY, NAME_SHORT, NAME_FULL, NAME_ONES, NAME_ZERO_INSIDE
    } t_name_shape;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tffm_byte_if rx_ch();
    tffm_res_if  res_ch();
    tffm_cfg_if  cfg_ch();

    text_frame_field_matcher_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Frame parser state as the block should hold it
    t_phase                     frame_phase = WAIT_START;
    tffm_pkg::t_index           field_pos   = '0;
    logic [2:0]                 name_ok     = '0;
    logic [tffm_pkg::NameW-1:0] value_acc   = '0;
    logic                       too_long    = 1'b0;
    tffm_pkg::t_names           cfg_names   = '0;

    tffm_pkg::t_result          expected_frames[$];
    logic [tffm_pkg::ByteW-1:0] frame_bytes[$];
    tffm_pkg::t_names           stim_names = '0;

    int error_count     = 0;
    int bytes_taken     = 0;
    int frames_expected = 0;
    int frames_checked  = 0;
    int reg_writes      = 0;
    int idle_cycles     = 0;

    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int sink_gap      = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Pick an idle gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [tffm_pkg::NameW-1:0] name_of(t_phase p);
        case (p)
            IN_MASTER: return cfg_names.master;
            IN_SLAVE:  return cfg_names.slave;
            default:   return cfg_names.variable;
        endcase
    endfunction

    function automatic logic [tffm_pkg::ByteW-1:0] closer_of(t_phase p);
        case (p)
            IN_MASTER:   return tffm_pkg::CH_HASH;
            IN_SLAVE:    return tffm_pkg::CH_DOLLAR;
            IN_VARIABLE: return tffm_pkg::CH_PCT;
            IN_VALUE:    return tffm_pkg::CH_BANG;
            default:     return tffm_pkg::CH_NONE;
        endcase
    endfunction

    // Advance the expected parser by one received byte; emit marks a result word
    function automatic void step_frame_parser(input logic [tffm_pkg::ByteW-1:0] c,
                                              output logic emit,
                                              output tffm_pkg::t_result word);
        int                         flag;
        logic [tffm_pkg::NameW-1:0] cfg_name;
        emit     = 1'b0;
        word     = '0;
        flag     = int'(frame_phase) - 1;
        cfg_name = name_of(frame_phase);
        // '@' restarts a frame from any phase
        if (c == tffm_pkg::CH_AT) begin
            frame_phase = IN_MASTER;
            name_ok     = 3'b001;
            value_acc   = '0;
            too_long    = 1'b0;
            field_pos   = '0;
            return;
        end
        if (frame_phase == WAIT_START) return;
        if (c inside {tffm_pkg::CH_HASH, tffm_pkg::CH_DOLLAR, tffm_pkg::CH_PCT,
                      tffm_pkg::CH_BANG}) begin
            // drop the frame on a delimiter out of order
            if (c != closer_of(frame_phase)) begin
                frame_phase = WAIT_START;
                return;
            end
            if (frame_phase == IN_VALUE) begin
                emit                = 1'b1;
                word.frame_match    = (name_ok == 3'b111) && !too_long;
                word.value_bytes    = value_acc;
                word.value_length   = field_pos;
                word.field_overflow = too_long;
                frame_phase         = WAIT_START;
                return;
            end
            // close the name: register bytes past the received ones must be zero
            if (field_pos < tffm_pkg::NameB && (cfg_name >> (8 * field_pos)) != '0)
                name_ok[flag] = 1'b0;
            frame_phase = t_phase'(frame_phase + 3'd1);
            if (frame_phase != IN_VALUE) name_ok[flag + 1] = 1'b1;
            else value_acc = '0;
            field_pos = '0;
            return;
        end
        // ordinary character inside a field
        if (field_pos >= tffm_pkg::FIELD_CHARS) begin
            too_long = 1'b1;
            if (frame_phase != IN_VALUE) name_ok[flag] = 1'b0;
            return;
        end
        if (frame_phase == IN_VALUE)
            value_acc[8 * field_pos +: 8] = c;
        else if (cfg_name[8 * field_pos +: 8] != c)
            name_ok[flag] = 1'b0;
        field_pos = field_pos + 1'b1;
    endfunction

    task automatic report(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Compare one result word with the oldest expected frame
    task automatic check_frame_result();
        tffm_pkg::t_result want;
        if (expected_frames.size() == 0) begin
            report($sformatf("result word with no frame pending, value %h",
                             res_ch.value_bytes));
            return;
        end
        want = expected_frames.pop_front();
        frames_checked++;
        if (res_ch.frame_match !== want.frame_match)
            report($sformatf("frame %0d match %b, want %b", frames_checked,
                             res_ch.frame_match, want.frame_match));
        if (res_ch.value_bytes !== want.value_bytes)
            report($sformatf("frame %0d value %h, want %h", frames_checked,
                             res_ch.value_bytes, want.value_bytes));
        if (res_ch.value_length !== want.value_length)
            report($sformatf("frame %0d length %0d, want %0d", frames_checked,
                             res_ch.value_length, want.value_length));
        if (res_ch.field_overflow !== want.field_overflow)
            report($sformatf("frame %0d overflow %b, want %b", frames_checked,
                             res_ch.field_overflow, want.field_overflow));
    endtask

    // Track register writes, check result words and predict from accepted bytes
    always @(posedge i_clk) begin : monitor
        logic              emit;
        tffm_pkg::t_result word;
        logic              busy;
        busy = 1'b0;
        if (!i_rst_n) begin
            frame_phase = WAIT_START;
            field_pos   = '0;
            name_ok     = '0;
            value_acc   = '0;
            too_long    = 1'b0;
            cfg_names   = '0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                busy = 1'b1;
                reg_writes++;
                case (cfg_ch.index)
                    tffm_pkg::REG_MASTER:   cfg_names.master   = cfg_ch.data;
                    tffm_pkg::REG_SLAVE:    cfg_names.slave    = cfg_ch.data;
                    tffm_pkg::REG_VARIABLE: cfg_names.variable = cfg_ch.data;
                    default: ;
                endcase
            end
            if (res_ch.valid && res_ch.ready) begin
                busy = 1'b1;
                check_frame_result();
            end
            if (rx_ch.valid && rx_ch.ready) begin
                busy = 1'b1;
                bytes_taken++;
                step_frame_parser(rx_ch.rx_byte, emit, word);
                if (emit) begin
                    expected_frames.push_back(word);
                    frames_expected++;
                end
            end
        end
        idle_cycles = busy ? 0 : idle_cycles + 1;
    end

    // End the run when no word has moved for too long
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("watchdog: no word moved for %0d cycles, %0d frames outstanding",
                 WATCHDOG_LIMIT, expected_frames.size());
        $display("DONE: errors detected");
        $finish;
    end

    // Result receiver: long holds on request, random stalls otherwise
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_left = HOLD_CYCLES;
            hold_served++;
        end
        if (hold_left > 0) begin
            res_ch.ready <= 1'b0;
            hold_left--;
        end else if (sink_gap > 0) begin
            res_ch.ready <= 1'b0;
            sink_gap--;
        end else begin
            res_ch.ready <= 1'b1;
            sink_gap = sink_idle_en ? pick_gap() : 0;
        end
    end

    // Offer one byte and hold it until the block takes it
    task automatic send_byte(input logic [tffm_pkg::ByteW-1:0] b);
        int gap;
        gap = src_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_queued();
        foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
        frame_bytes.delete();
    endtask

    // Stop sending, wait for every pending frame, then let the pipeline settle
    task automatic wait_results_drained();
        rx_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all three name registers back to back; only while the block is idle
    task automatic write_names(input tffm_pkg::t_names n);
        logic [tffm_pkg::CfgIdxW-1:0] idx[3];
        logic [tffm_pkg::NameW-1:0]   val[3];
        idx = '{tffm_pkg::REG_MASTER, tffm_pkg::REG_SLAVE, tffm_pkg::REG_VARIABLE};
        val = '{n.master, n.slave, n.variable};
        stim_names = n;
        for (int i = 0; i < 3; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= val[i];
            @(posedge i_clk);
            while (!cfg_ch.ready) @(posedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [tffm_pkg::NameW-1:0] pack_name(input string s);
        logic [tffm_pkg::NameW-1:0] n;
        n = '0;
        for (int i = 0; i < s.len() && i < tffm_pkg::NameB; i++) n[8 * i +: 8] = s[i];
        return n;
    endfunction

    function automatic int name_len(input logic [tffm_pkg::NameW-1:0] n);
        int len;
        len = 0;
        for (int i = 0; i < tffm_pkg::NameB; i++) if (n[8 * i +: 8] != '0) len = i + 1;
        return len;
    endfunction

    // Any byte that is neither a delimiter nor a frame start
    function automatic logic [tffm_pkg::ByteW-1:0] rand_text_char();
        logic [tffm_pkg::ByteW-1:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c inside {tffm_pkg::CH_AT, tffm_pkg::CH_HASH, tffm_pkg::CH_DOLLAR,
                         tffm_pkg::CH_PCT, tffm_pkg::CH_BANG});
        return c;
    endfunction

    function automatic logic [tffm_pkg::NameW-1:0] rand_name(input t_name_shape shape);
        logic [tffm_pkg::NameW-1:0] n;
        int len;
        int hole;
        n = '0;
        case (shape)
            NAME_SHORT: begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) n[8 * i +: 8] = rand_text_char();
            end
            NAME_FULL: begin
                for (int i = 0; i < tffm_pkg::NameB; i++) n[8 * i +: 8] = rand_text_char();
            end
            NAME_ONES: n = '1;
            NAME_ZERO_INSIDE: begin
                len = $urandom_range(3, tffm_pkg::NameB);
                for (int i = 0; i < len; i++) n[8 * i +: 8] = rand_text_char();
                hole = $urandom_range(0, len - 2);
                n[8 * hole +: 8] = '0;
            end
            default: n = '0;
        endcase
        return n;
    endfunction

    function automatic void push_text(input int count);
        repeat (count) frame_bytes.push_back(rand_text_char());
    endfunction

    // Name field: mostly the configured name, else a prefix, a typo, noise or too long
    function automatic void push_name_field(input logic [tffm_pkg::NameW-1:0] n);
        int len;
        int pick;
        int start;
        int pos;
        logic [tffm_pkg::ByteW-1:0] c;
        len   = name_len(n);
        pick  = $urandom_range(0, 99);
        start = frame_bytes.size();
        if (pick < 55) begin
            for (int i = 0; i < len; i++) frame_bytes.push_back(n[8 * i +: 8]);
            if (len < tffm_pkg::NameB && $urandom_range(0, 9) == 0)
                frame_bytes.push_back(8'h00);
        end else if (pick < 65) begin
            pos = $urandom_range(0, len);
            for (int i = 0; i < pos; i++) frame_bytes.push_back(n[8 * i +: 8]);
        end else if (pick < 75 && len > 0) begin
            for (int i = 0; i < len; i++) frame_bytes.push_back(n[8 * i +: 8]);
            pos = $urandom_range(0, len - 1);
            do c = rand_text_char();
            while (c == n[8 * pos +: 8]);
            frame_bytes[start + pos] = c;
        end else if (pick < 90) begin
            push_text($urandom_range(0, tffm_pkg::FIELD_CHARS));
        end else begin
            push_text($urandom_range(tffm_pkg::FIELD_CHARS + 1, tffm_pkg::FIELD_CHARS + 4));
        end
    endfunction

    // Queue one frame; unless clean, sometimes with leading noise or cut short
    function automatic void push_frame(input bit clean);
        int pick;
        int start;
        int keep;
        pick  = clean ? 99 : $urandom_range(0, 99);
        if (pick < 8)
            repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom_range(0, 255)));
        start = frame_bytes.size();
        frame_bytes.push_back(tffm_pkg::CH_AT);
        push_name_field(stim_names.master);
        frame_bytes.push_back(tffm_pkg::CH_HASH);
        push_name_field(stim_names.slave);
        frame_bytes.push_back(tffm_pkg::CH_DOLLAR);
        push_name_field(stim_names.variable);
        frame_bytes.push_back(tffm_pkg::CH_PCT);
        if ($urandom_range(0, 99) < 10) push_text($urandom_range(tffm_pkg::FIELD_CHARS + 1, 11));
        else push_text($urandom_range(0, tffm_pkg::FIELD_CHARS));
        frame_bytes.push_back(tffm_pkg::CH_BANG);
        // cut the frame and end it with a stray delimiter or a fresh start
        if (pick >= 8 && pick < 20) begin
            keep = $urandom_range(1, frame_bytes.size() - start - 1);
            while (frame_bytes.size() > start + keep) void'(frame_bytes.pop_back());
            case ($urandom_range(0, 4))
                0:       frame_bytes.push_back(tffm_pkg::CH_HASH);
                1:       frame_bytes.push_back(tffm_pkg::CH_DOLLAR);
                2:       frame_bytes.push_back(tffm_pkg::CH_PCT);
                3:       frame_bytes.push_back(tffm_pkg::CH_BANG);
                default: frame_bytes.push_back(tffm_pkg::CH_AT);
            endcase
        end
    endfunction

    // Names at their reset value: only empty names match
    task automatic test_reset_names();
        send_text("@#$%Z!");
        wait_results_drained();
    endtask

    // Hand-picked frames: ignored bytes, restart, match, abort, long value
    task automatic test_directed_frames();
        tffm_pkg::t_names n;
        n.master   = pack_name("M");
        n.slave    = pack_name("S");
        n.variable = pack_name("V");
        write_names(n);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(tffm_pkg::CH_BANG);
        send_text("@Q");
        send_text("@M#S$V%");
        send_byte(8'hFF);
        send_byte(tffm_pkg::CH_BANG);
        send_text("@M$");
        send_text("@M#S$V%123456789!");
        wait_results_drained();
    endtask

    // Every name shape on all three registers, extremes included
    task automatic test_name_shapes();
        tffm_pkg::t_names n;
        for (int s = NAME_EMPTY; s <= NAME_ZERO_INSIDE; s++) begin
            n.master   = rand_name(t_name_shape'(s));
            n.slave    = rand_name(t_name_shape'(s));
            n.variable = rand_name(t_name_shape'(s));
            write_names(n);
            repeat (2) begin
                push_frame(1'b0);
                send_queued();
            end
            wait_results_drained();
        end
    endtask

    // Hold the receiver off while frames keep coming so the input stalls
    task automatic test_result_backpressure();
        tffm_pkg::t_names n;
        n.master   = rand_name(NAME_SHORT);
        n.slave    = rand_name(NAME_SHORT);
        n.variable = rand_name(NAME_SHORT);
        write_names(n);
        src_idle_en = 1'b0;
        hold_requests++;
        repeat (6) begin
            push_frame(1'b1);
            send_queued();
        end
        wait_results_drained();
        src_idle_en = 1'b1;
    endtask

    // Random frames under random names, draining before each new setting
    task automatic test_random_traffic();
        tffm_pkg::t_names n;
        do begin
            n.master   = rand_name(t_name_shape'($urandom_range(NAME_EMPTY, NAME_ZERO_INSIDE)));
            n.slave    = rand_name(t_name_shape'($urandom_range(NAME_EMPTY, NAME_ZERO_INSIDE)));
            n.variable = rand_name(t_name_shape'($urandom_range(NAME_EMPTY, NAME_ZERO_INSIDE)));
            write_names(n);
            src_idle_en  = ($urandom_range(0, 3) != 0);
            sink_idle_en = ($urandom_range(0, 3) != 0);
            repeat (8) begin
                push_frame(1'b0);
                send_queued();
            end
            wait_results_drained();
        end while (bytes_taken < TOTAL_BYTES);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = tffm_pkg::REG_MASTER;
        cfg_ch.data   = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_names();
        test_directed_frames();
        test_name_shapes();
        test_result_backpressure();
        test_random_traffic();

        $display("Run covered %0d received bytes, %0d of %0d frame results and %0d writes,",
                 bytes_taken, frames_checked, frames_expected, reg_writes);
        $display("with name shapes from empty to all ones, long fields and a stalled receiver.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/tffm_pkg.sv
sv/tffm_ifs.sv
sv/tffm_cfg_regs.sv
sv/tffm_in_reg.sv
sv/tffm_parser.sv
sv/tffm_out_queue.sv
sv/text_frame_field_matcher_unit.sv
tb/testbench.sv
